// ===== rtl/fbad_pkg.sv =====
// Shared types, constants and register codes of the flow baseline anomaly detector.
// Used by fbad_eval and by the top level flow_baseline_anomaly_detector.
package fbad_pkg;

  localparam int SLOTS = 1024;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int COUNT_BITS = 24;
  localparam int NOISE_FLOOR = 10;

  localparam int SLOT_IN_BITS = 10;
  localparam int PACKET_BITS = 16;
  localparam int SEEN_BITS = 24;
  localparam int BASE_BITS = 32;
  localparam int WAIT_BITS = 8;
  localparam int AGE_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Product widths of the three multipliers.
  localparam int KEEP_PROD_BITS = 16 + BASE_BITS;
  localparam int NEW_PROD_BITS = 16 + COUNT_BITS;
  localparam int THR_PROD_BITS = 8 + BASE_BITS;

  // Command codes.
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALERT_LIMIT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARN_POLLS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_MULT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KEEP_WEIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEW_WEIGHT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DYN_MODE = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [7:0] ALERT_LIMIT_RST = 8'd3;
  localparam logic [15:0] LEARN_POLLS_RST = 16'd10;
  localparam logic [7:0] RATE_MULT_RST = 8'd2;
  localparam logic [15:0] KEEP_WEIGHT_RST = 16'd32768;
  localparam logic [15:0] NEW_WEIGHT_RST = 16'd16384;
  localparam logic DYN_MODE_RST = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic                  learnt;
    logic [COUNT_BITS-1:0] count;
    logic [BASE_BITS-1:0]  baseline;
    logic [WAIT_BITS-1:0]  wait_cnt;
    logic                  flagged;
    logic [AGE_BITS-1:0]   age;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic [7:0]  alert_limit;
    logic [15:0] learn_polls;
    logic [7:0]  rate_mult;
    logic        dyn_mode;
  } cfg_t;

  typedef struct packed {
    logic   write;
    logic   result;
    logic   alert;
    entry_t entry;
    logic [SEEN_BITS-1:0] seen;
  } eval_t;

endpackage

// ===== rtl/flow_baseline_anomaly_detector.sv =====
// Flow baseline anomaly detector: per-slot EWMA baseline and suspicion check.
// A poll result passes the RAM read, the entry and product registers and then
// the result register, held back only while the previous result still waits.
// A new item is taken only after the last one's read, multiply and write back.
// Reset: control clears at once, then a pass writes every slot entry to zero
// (SLOTS entries, 1024), during which no item is accepted.
module flow_baseline_anomaly_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fbad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fbad_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [fbad_pkg::SLOT_IN_BITS-1:0]    slot,
  input  logic [fbad_pkg::PACKET_BITS-1:0]     packets,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fbad_pkg::SLOT_IN_BITS-1:0]    slot_out,
  output logic                                 alert,
  output logic                                 suspicious,
  output logic                                 learnt,
  output logic [fbad_pkg::BASE_BITS-1:0]       baseline_out,
  output logic [fbad_pkg::SEEN_BITS-1:0]       count_seen
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC} state_t;

  state_t                               state;
  fbad_pkg::cfg_t                       cfg;
  logic [15:0]                          keep_weight;
  logic [15:0]                          new_weight;
  logic [fbad_pkg::SLOT_BITS-1:0]       clr_addr;

  logic                                 it_cmd;
  logic [fbad_pkg::SLOT_IN_BITS-1:0]    it_slot;
  logic [fbad_pkg::PACKET_BITS-1:0]     it_packets;
  logic                                 it_in_range;
  fbad_pkg::entry_t                     ent;
  logic [fbad_pkg::KEEP_PROD_BITS-1:0]  keep_prod;
  logic [fbad_pkg::NEW_PROD_BITS-1:0]   new_prod;
  logic [fbad_pkg::THR_PROD_BITS-1:0]   thr_prod;

  logic [fbad_pkg::ENTRY_BITS-1:0]      rdata;
  fbad_pkg::entry_t                     rd_entry;
  fbad_pkg::eval_t                      ev;
  logic                                 ram_we;
  logic [fbad_pkg::SLOT_BITS-1:0]       ram_waddr;
  logic [fbad_pkg::ENTRY_BITS-1:0]      ram_wdata;
  logic                                 exec_go;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign rd_entry = fbad_pkg::entry_t'(rdata);

  // The result register must be free before a poll with a result may retire.
  assign exec_go = (state == S_EXEC) && (!ev.result || !out_valid || out_ready);

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = exec_go && ev.write;
      ram_waddr = fbad_pkg::SLOT_BITS'(it_slot);
      ram_wdata = ev.entry;
    end
  end

  fbad_ram #(
    .ADDR_BITS (fbad_pkg::SLOT_BITS),
    .DATA_BITS (fbad_pkg::ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (fbad_pkg::SLOT_BITS'(slot)),
    .rdata (rdata)
  );

  fbad_eval u_eval (
    .cmd       (it_cmd),
    .packets   (it_packets),
    .in_range  (it_in_range),
    .entry     (ent),
    .keep_prod (keep_prod),
    .new_prod  (new_prod),
    .thr_prod  (thr_prod),
    .cfg       (cfg),
    .res       (ev)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alert_limit <= fbad_pkg::ALERT_LIMIT_RST;
      cfg.learn_polls <= fbad_pkg::LEARN_POLLS_RST;
      cfg.rate_mult <= fbad_pkg::RATE_MULT_RST;
      cfg.dyn_mode <= fbad_pkg::DYN_MODE_RST;
      keep_weight <= fbad_pkg::KEEP_WEIGHT_RST;
      new_weight <= fbad_pkg::NEW_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbad_pkg::CFG_ALERT_LIMIT: cfg.alert_limit <= cfg_data[7:0];
        fbad_pkg::CFG_LEARN_POLLS: cfg.learn_polls <= cfg_data;
        fbad_pkg::CFG_RATE_MULT:   cfg.rate_mult <= cfg_data[7:0];
        fbad_pkg::CFG_KEEP_WEIGHT: keep_weight <= cfg_data;
        fbad_pkg::CFG_NEW_WEIGHT:  new_weight <= cfg_data;
        fbad_pkg::CFG_DYN_MODE:    cfg.dyn_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Item payload, fetched entry and products.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      it_cmd <= cmd;
      it_slot <= slot;
      it_packets <= packets;
      it_in_range <= (32'(slot) < 32'(fbad_pkg::SLOTS));
    end
    if (state == S_READ) begin
      ent <= rd_entry;
      keep_prod <= fbad_pkg::KEEP_PROD_BITS'(keep_weight)
                 * fbad_pkg::KEEP_PROD_BITS'(rd_entry.baseline);
      new_prod <= fbad_pkg::NEW_PROD_BITS'(new_weight)
                * fbad_pkg::NEW_PROD_BITS'(rd_entry.count);
      thr_prod <= fbad_pkg::THR_PROD_BITS'(cfg.rate_mult)
                * fbad_pkg::THR_PROD_BITS'(rd_entry.baseline);
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec_go && ev.result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == fbad_pkg::SLOT_BITS'(fbad_pkg::SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && ev.result) begin
      slot_out <= it_slot;
      alert <= ev.alert;
      suspicious <= ev.entry.flagged;
      learnt <= ev.entry.learnt;
      baseline_out <= ev.entry.baseline;
      count_seen <= ev.seen;
    end
  end

endmodule

// ===== rtl/fbad_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic; holds the per-slot entries of the detector.
module fbad_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fbad_eval.sv =====
// Next-entry logic: count accumulation, learning update and the suspicion check.
// Works on a registered entry and registered products; uses fbad_pkg.
module fbad_eval (
  input  logic                                cmd,
  input  logic [fbad_pkg::PACKET_BITS-1:0]    packets,
  input  logic                                in_range,
  input  fbad_pkg::entry_t                    entry,
  input  logic [fbad_pkg::KEEP_PROD_BITS-1:0] keep_prod,
  input  logic [fbad_pkg::NEW_PROD_BITS-1:0]  new_prod,
  input  logic [fbad_pkg::THR_PROD_BITS-1:0]  thr_prod,
  input  fbad_pkg::cfg_t                      cfg,
  output fbad_pkg::eval_t                     res
);

  localparam int SUM_BITS = 58;
  localparam int CMP_BITS = 41;
  localparam logic [32:0] COUNT_MAX = 33'({fbad_pkg::COUNT_BITS{1'b1}});

  logic [32:0]                        sum_cnt;
  logic [32:0]                        new_cnt;
  logic [SUM_BITS-1:0]                acc;
  logic [fbad_pkg::BASE_BITS-1:0]     base_upd;
  logic [CMP_BITS-1:0]                lhs;
  logic [CMP_BITS-1:0]                rhs;
  logic [fbad_pkg::COUNT_BITS-1:0]    seen;
  logic [fbad_pkg::WAIT_BITS-1:0]     wait_inc;
  fbad_pkg::entry_t                   nxt;

  always_comb begin
    seen = entry.count;
    sum_cnt = 33'(entry.count) + 33'(packets);
    new_cnt = 33'(packets);
    acc = SUM_BITS'(keep_prod) + (SUM_BITS'(new_prod) << 8);
    // Drop the Q0.16 fraction and saturate to the baseline width.
    if (acc[SUM_BITS-1:48] != '0) begin
      base_upd = '1;
    end else begin
      base_upd = acc[47:16];
    end
    lhs = CMP_BITS'(seen) << 8;
    rhs = CMP_BITS'(thr_prod) + CMP_BITS'(fbad_pkg::NOISE_FLOOR * 256);
    wait_inc = (entry.wait_cnt == '1) ? entry.wait_cnt : entry.wait_cnt + 1'b1;

    nxt = entry;
    res = '0;

    if (cmd == fbad_pkg::CMD_COUNT) begin
      res.write = in_range;
      if (!entry.valid) begin
        nxt = '0;
        nxt.valid = 1'b1;
        nxt.count = (new_cnt > COUNT_MAX) ? '1 : fbad_pkg::COUNT_BITS'(new_cnt);
      end else begin
        nxt.count = (sum_cnt > COUNT_MAX) ? '1 : fbad_pkg::COUNT_BITS'(sum_cnt);
      end
    end else if (entry.valid) begin
      res.write = in_range;
      res.result = in_range;
      if (!entry.learnt) begin
        if (entry.age < cfg.learn_polls) begin
          nxt.baseline = base_upd;
          nxt.count = '0;
          nxt.age = entry.age + 1'b1;
        end else begin
          nxt.learnt = 1'b1;
        end
      end else if (seen != '0) begin
        if (lhs > rhs) begin
          nxt.wait_cnt = wait_inc;
          nxt.flagged = 1'b1;
          res.alert = (wait_inc >= cfg.alert_limit);
        end else if (entry.wait_cnt != '0) begin
          nxt.wait_cnt = '0;
          nxt.flagged = 1'b0;
        end else if (cfg.dyn_mode) begin
          nxt.baseline = base_upd;
        end
        nxt.count = '0;
      end
    end

    res.entry = nxt;
    if (32'(seen) > 32'({fbad_pkg::SEEN_BITS{1'b1}})) begin
      res.seen = '1;
    end else begin
      res.seen = fbad_pkg::SEEN_BITS'(seen);
    end
  end

endmodule
